// ----- rtl/abps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abps_pkg
// Types, tables and constants shared by the band peak smoother files.
// ----------------------------------------------------------------------------
package abps_pkg;

  localparam int BINS_DEFAULT = 64;
  localparam int DT_BITS      = 18;
  localparam int TANH_LAST    = 48;
  localparam int MUL_W        = 25;
  localparam logic [24:0] ONE_Q24 = 25'h100_0000;

  typedef struct packed {
    logic [5:0]  bin_index;
    logic [15:0] magnitude;
    logic [17:0] frame_dt_us;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  resolution;
    logic [5:0]  band_index;
    logic [15:0] level;
    logic        last;
  } out_word_t;

  typedef enum logic [1:0] {
    RES_16 = 2'd0,
    RES_32 = 2'd1,
    RES_64 = 2'd2
  } res_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_TANH,
    ST_CMP,
    ST_DECAY,
    ST_UPD,
    ST_WRITE
  } state_e;

  localparam logic [15:0] TILT_GAIN [64] = '{
    16'd5987,  16'd6978,  16'd7719,  16'd8324,  16'd8840,  16'd9295,  16'd9703,  16'd10074,
    16'd10416, 16'd10733, 16'd11030, 16'd11309, 16'd11574, 16'd11824, 16'd12063, 16'd12292,
    16'd12511, 16'd12721, 16'd12923, 16'd13119, 16'd13307, 16'd13490, 16'd13667, 16'd13839,
    16'd14006, 16'd14169, 16'd14327, 16'd14482, 16'd14632, 16'd14779, 16'd14923, 16'd15063,
    16'd15201, 16'd15336, 16'd15468, 16'd15597, 16'd15724, 16'd15971, 16'd16383, 16'd16880,
    16'd17394, 16'd17876, 16'd18416, 16'd18962, 16'd19512, 16'd20100, 16'd20683, 16'd21292,
    16'd21921, 16'd22565, 16'd23245, 16'd23929, 16'd24636, 16'd25381, 16'd26118, 16'd26880,
    16'd27681, 16'd28509, 16'd29357, 16'd30221, 16'd31121, 16'd32048, 16'd32994, 16'd33965
  };

  localparam logic [15:0] TANH_TAB [TANH_LAST+1] = '{
    16'd0,     16'd8150,  16'd16051, 16'd23485, 16'd30285, 16'd36346, 16'd41625,
    16'd46152, 16'd49912, 16'd53038, 16'd55593, 16'd57670, 16'd59320, 16'd60639,
    16'd61694, 16'd62532, 16'd63179, 16'd63691, 16'd64096, 16'd64412, 16'd64659,
    16'd64852, 16'd65003, 16'd65120, 16'd65212, 16'd65283, 16'd65339, 16'd65383,
    16'd65417, 16'd65443, 16'd65464, 16'd65480, 16'd65492, 16'd65502, 16'd65509,
    16'd65515, 16'd65520, 16'd65523, 16'd65526, 16'd65528, 16'd65530, 16'd65531,
    16'd65532, 16'd65533, 16'd65534, 16'd65534, 16'd65535, 16'd65535, 16'd65535
  };

  localparam logic [23:0] ATTACK_DECAY [DT_BITS] = '{
    24'd16776377, 24'd16775538, 24'd16773861, 24'd16770506, 24'd16763800, 24'd16750394,
    24'd16723615, 24'd16670185, 24'd16563836, 24'd16353170, 24'd15939842, 24'd15144263,
    24'd13670248, 24'd11138659, 24'd7395132,  24'd3259658,  24'd633322,   24'd23907
  };

  localparam logic [23:0] RELEASE_DECAY [DT_BITS] = '{
    24'd16777123, 24'd16777030, 24'd16776843, 24'd16776470, 24'd16775725, 24'd16774234,
    24'd16771252, 24'd16765290, 24'd16753372, 24'd16729562, 24'd16682043, 24'd16587410,
    24'd16399752, 24'd16030781, 24'd15317555, 24'd13984888, 24'd11657303, 24'd8099837
  };

endpackage

// ----- rtl/audio_band_peak_smoother_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_band_peak_smoother_unit
// Tilt, group peaks, tanh shaping and attack/release smoothing of band levels.
// ----------------------------------------------------------------------------
// Input channel: one word per spectrum bin (bin index, Q4.12 magnitude, frame
// time in us), bins in ascending order. A word is taken when in_valid_i is
// high and in_stall_o is low; in_stall_o is high whenever the unit is busy.
// Output channel: one to three words per bin (16-band, 32-band, then 64-band
// result, the last flagged), held in an output register until taken.
// Steps: the bin is scaled once, then each band passes a tanh step, a compare
// step, a decay walk and an update (both only when the frame time is
// non-zero) and a write step. The scale, tanh, decay and update steps share
// the single 25x25 multiplier, and the decay is a bitwise walk over the 18
// decay factors.
// Reset clears the group peaks and a valid bit for every level entry, so all
// levels read as zero straight after reset with no clearing pass.
// A stalled output holds the write cycle until the register frees; no
// further input word is taken meanwhile.
// ----------------------------------------------------------------------------
module audio_band_peak_smoother_unit
  import abps_pkg::*;
#(
  parameter int BINS = BINS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int G32_BASE = BINS / 4;
  localparam int G64_BASE = BINS / 4 + BINS / 2;
  localparam int DEPTH    = BINS / 4 + BINS / 2 + BINS;
  localparam int AW       = $clog2(DEPTH);
  localparam int BW       = $clog2(DT_BITS);

  state_e state_q, state_d;
  res_e   res_q, res_d;

  // latched input word
  logic [5:0]  bin_q;
  logic [15:0] mag_q;
  logic [17:0] dt_q;

  logic [31:0] v_q, peak4_q, peak2_q;
  logic [15:0] t_q, prev_q, next_q;
  logic [24:0] r_q;
  logic [BW-1:0] b_q;
  logic        up_q;
  logic [DEPTH-1:0] valid_q;

  logic        out_valid_q;
  out_word_t   out_q;

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;

  logic        in_take;
  logic        out_free;
  logic        do_write;
  logic [AW-1:0] slot;
  logic [31:0] peak;
  logic [5:0]  band;
  logic [5:0]  tidx;
  logic [15:0] t_lo, t_hi;
  logic [15:0] rd_data, prev;
  logic [23:0] dec_f;
  logic [24:0] alpha;
  logic [15:0] step;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign do_write   = (state_q == ST_WRITE) && out_free;

  // band slot, peak and number for the band in hand
  always_comb begin
    case (res_q)
      RES_16: begin
        slot = AW'(bin_q >> 2);
        peak = peak4_q;
        band = bin_q >> 2;
      end
      RES_32: begin
        slot = AW'(G32_BASE + 32'(bin_q >> 1));
        peak = peak2_q;
        band = bin_q >> 1;
      end
      default: begin
        slot = AW'(G64_BASE + 32'(bin_q));
        peak = v_q;
        band = bin_q;
      end
    endcase
  end

  // tanh interpolation points
  assign tidx = peak[27:22];
  assign t_lo = TANH_TAB[tidx];
  assign t_hi = TANH_TAB[6'(tidx + 6'd1)];

  assign prev  = valid_q[slot] ? rd_data : 16'd0;
  assign dec_f = up_q ? ATTACK_DECAY[b_q] : RELEASE_DECAY[b_q];
  assign alpha = ONE_Q24 - r_q;
  assign step  = prod[39:24];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SCALE: begin
        mul_a = MUL_W'(mag_q);
        mul_b = MUL_W'(TILT_GAIN[bin_q]);
      end
      ST_TANH: begin
        mul_a = MUL_W'(t_hi - t_lo);
        mul_b = MUL_W'(peak[21:6]);
      end
      ST_DECAY: begin
        mul_a = r_q;
        mul_b = MUL_W'(dec_f);
      end
      ST_UPD: begin
        mul_a = MUL_W'(up_q ? (t_q - prev_q) : (prev_q - t_q));
        mul_b = alpha;
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  abps_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_level_ram (
    .clk_i  (clk_i),
    .we_i   (do_write),
    .waddr_i(slot),
    .wdata_i(next_q),
    .re_i   (state_q == ST_TANH),
    .raddr_i(slot),
    .rdata_o(rd_data)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take && (32'(in_word_i.bin_index) < BINS)) begin
          state_d = ST_SCALE;
          if (in_word_i.bin_index[1:0] == 2'b11) begin
            res_d = RES_16;
          end else if (in_word_i.bin_index[0]) begin
            res_d = RES_32;
          end else begin
            res_d = RES_64;
          end
        end
      end
      ST_SCALE: state_d = ST_TANH;
      ST_TANH:  state_d = ST_CMP;
      ST_CMP:   state_d = (dt_q == '0) ? ST_WRITE : ST_DECAY;
      ST_DECAY: begin
        if (32'(b_q) == DT_BITS - 1) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD:   state_d = ST_WRITE;
      ST_WRITE: begin
        if (out_free) begin
          unique case (res_q)
            RES_16: begin
              res_d   = RES_32;
              state_d = ST_TANH;
            end
            RES_32: begin
              res_d   = RES_64;
              state_d = ST_TANH;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_q   <= RES_64;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // control state: peaks, valid bits, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak4_q     <= '0;
      peak2_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_SCALE) begin
        if (bin_q[1:0] == 2'b00 || prod[31:0] > peak4_q) begin
          peak4_q <= prod[31:0];
        end
        if (!bin_q[0] || prod[31:0] > peak2_q) begin
          peak2_q <= prod[31:0];
        end
      end
      if (do_write) begin
        valid_q[slot] <= 1'b1;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      bin_q <= in_word_i.bin_index;
      mag_q <= in_word_i.magnitude;
      dt_q  <= in_word_i.frame_dt_us;
    end
    case (state_q)
      ST_SCALE: v_q <= prod[31:0];
      ST_TANH: begin
        if (peak[31:22] >= 10'(TANH_LAST)) begin
          t_q <= 16'hFFFF;
        end else begin
          t_q <= t_lo + prod[31:16];
        end
      end
      ST_CMP: begin
        prev_q <= prev;
        up_q   <= t_q > prev;
        next_q <= t_q;
        r_q    <= ONE_Q24;
        b_q    <= '0;
      end
      ST_DECAY: begin
        if (dt_q[b_q]) begin
          r_q <= prod[48:24];
        end
        b_q <= BW'(b_q + 1'b1);
      end
      ST_UPD: next_q <= up_q ? (prev_q + step) : (prev_q - step);
      default: ;
    endcase
    if (do_write) begin
      out_q.resolution <= res_q;
      out_q.band_index <= band;
      out_q.level      <= next_q;
      out_q.last       <= (res_q == RES_64);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- rtl/abps_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module abps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 112
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
